### sv/pls_pkg.sv
package pls_pkg;

    // Field and datapath widths
    localparam int OFFSET_W = 16;
    localparam int SCALE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 16;
    localparam int TURN_W   = 8;
    localparam int POS_W    = 24;
    localparam int ISUM_W   = 18;
    localparam int DIFF_W   = POS_W + 1;
    localparam int OPA_W    = GAIN_W + 1;
    localparam int OPB_W    = DIFF_W;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = ACC_W - FRAC_W;

    // APB
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    typedef enum logic [2:0] {
        REG_POS_SCALE      = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_TURN_LIMIT     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_SAT,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_ABS,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        [SCALE_W-1:0] pos_scale;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] integral_limit;
        logic        [TURN_W-1:0]  turn_limit;
    } t_cfg;

    typedef struct packed {
        logic                     mul_en;
        logic                     acc_en;
        logic                     acc_clr;
        logic signed [OPA_W-1:0]  op_a;
        logic signed [OPB_W-1:0]  op_b;
    } t_mac_ctl;

endpackage

### sv/pls_if.sv
interface pls_in_if;
    import pls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] line_offset;

    modport source (output valid, output line_offset, input ready);
    modport sink   (input valid, input line_offset, output ready);
endinterface

interface pls_out_if;
    import pls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TURN_W:0]   turn_signed;
    logic        [1:0]        turn_dir;
    logic        [TURN_W-1:0] turn_mag;

    modport source (output valid, output turn_signed, output turn_dir, output turn_mag,
                    input ready);
    modport sink   (input valid, input turn_signed, input turn_dir, input turn_mag,
                    output ready);
endinterface

### sv/pls_regs.sv
module pls_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pls_pkg::ADDR_W-1:0] paddr,
    input  logic [pls_pkg::DATA_W-1:0] pwdata,
    output logic [pls_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output pls_pkg::t_cfg              o_cfg
);
    import pls_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_scale      <= SCALE_W'(256);
            r_cfg.gain_p         <= GAIN_W'(256);
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_limit <= '1;
            r_cfg.turn_limit     <= TURN_W'(7);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POS_SCALE:      r_cfg.pos_scale      <= pwdata[SCALE_W-1:0];
                REG_GAIN_P:         r_cfg.gain_p         <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:         r_cfg.gain_i         <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:         r_cfg.gain_d         <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= pwdata[LIMIT_W-1:0];
                REG_TURN_LIMIT:     r_cfg.turn_limit     <= pwdata[TURN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POS_SCALE:      prdata = DATA_W'(r_cfg.pos_scale);
            REG_GAIN_P:         prdata = DATA_W'($unsigned(r_cfg.gain_p));
            REG_GAIN_I:         prdata = DATA_W'($unsigned(r_cfg.gain_i));
            REG_GAIN_D:         prdata = DATA_W'($unsigned(r_cfg.gain_d));
            REG_INTEGRAL_LIMIT: prdata = DATA_W'(r_cfg.integral_limit);
            REG_TURN_LIMIT:     prdata = DATA_W'(r_cfg.turn_limit);
            default:            prdata = '0;
        endcase
    end

endmodule

### sv/pls_mac.sv
module pls_mac (
    input  logic                              i_clk,
    input  pls_pkg::t_mac_ctl                 i_ctl,
    output logic signed [pls_pkg::PROD_W-1:0] o_prod,
    output logic signed [pls_pkg::ACC_W-1:0]  o_acc
);
    import pls_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // product register, then accumulate on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_ctl.op_a * i_ctl.op_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= (i_ctl.acc_clr ? '0 : r_acc) + w_prod_ext;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

### sv/pid_line_steering.sv
// Channel    | Dir | Handshake       | Payload
// -----------+-----+-----------------+------------------------------------------
// i_line     | in  | valid / ready   | line_offset (s16)
// o_steer    | out | valid / ready   | turn_signed (s9), turn_dir (2), turn_mag (8)
// APB        | in  | psel / penable  | paddr (5), pwdata / prdata (32), pready = 1
//
// A request passes through the accepting idle state, then eight sequencer steps
// around the single 17x25 signed multiplier; the result loads into the output
// register in the last step. The multiplier runs four times per
// request (scale, then P, I and D terms).
// Reset (synchronous, active low) clears the sequencer, the output valid, the
// integral and the previous position, and loads the register defaults.
// A new request is taken while a finished result still waits at the output;
// the sequencer only holds in its last step if the output is full and not ready.
module pid_line_steering (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pls_in_if.sink                     i_line,
    pls_out_if.source                  o_steer,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pls_pkg::ADDR_W-1:0] paddr,
    input  logic [pls_pkg::DATA_W-1:0] pwdata,
    output logic [pls_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pls_pkg::*;

    t_cfg     w_cfg;
    t_mac_ctl w_mac_ctl;
    t_state   r_state, n_state;

    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_acc;

    // per-request working registers
    logic signed [OFFSET_W-1:0] r_offset;
    logic signed [POS_W-1:0]    r_pos;
    logic signed [ISUM_W-1:0]   r_integ;
    logic signed [DIFF_W-1:0]   r_deriv;
    logic        [MAG_W-1:0]    r_mag;
    logic                       r_neg;

    // controller state carried between requests
    logic signed [POS_W-1:0]    r_prev_pos;
    logic signed [ISUM_W-1:0]   r_isum;

    // output register
    logic                       r_out_valid;
    logic signed [TURN_W:0]     r_turn_signed;
    logic        [1:0]          r_turn_dir;
    logic        [TURN_W-1:0]   r_turn_mag;

    logic w_in_acc;
    logic w_out_free;
    logic w_load_out;

    pls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pls_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    assign i_line.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_line.valid && i_line.ready;
    assign w_out_free   = !r_out_valid || o_steer.ready;
    assign w_load_out   = (r_state == S_OUT) && w_out_free;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_POS;
            S_POS:   n_state = S_SAT;
            S_SAT:   n_state = S_MUL_P;
            S_MUL_P: n_state = S_MUL_I;
            S_MUL_I: n_state = S_MUL_D;
            S_MUL_D: n_state = S_ACC;
            S_ACC:   n_state = S_ABS;
            S_ABS:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- sequencer: multiplier control ----------------
    // Each gain product is accumulated in the step after it; the scale product feeds S_SAT.
    always_comb begin
        w_mac_ctl = '0;
        unique case (r_state)
            S_POS: begin
                w_mac_ctl.mul_en = 1'b1;
                w_mac_ctl.op_a   = $signed({1'b0, w_cfg.pos_scale});
                w_mac_ctl.op_b   = OPB_W'(r_offset);
            end
            S_MUL_P: begin
                w_mac_ctl.mul_en = 1'b1;
                w_mac_ctl.op_a   = OPA_W'(w_cfg.gain_p);
                w_mac_ctl.op_b   = OPB_W'(r_pos);
            end
            S_MUL_I: begin
                w_mac_ctl.mul_en  = 1'b1;
                w_mac_ctl.acc_en  = 1'b1;
                w_mac_ctl.acc_clr = 1'b1;
                w_mac_ctl.op_a    = OPA_W'(w_cfg.gain_i);
                w_mac_ctl.op_b    = OPB_W'(r_integ);
            end
            S_MUL_D: begin
                w_mac_ctl.mul_en = 1'b1;
                w_mac_ctl.acc_en = 1'b1;
                w_mac_ctl.op_a   = OPA_W'(w_cfg.gain_d);
                w_mac_ctl.op_b   = r_deriv;
            end
            S_ACC: begin
                w_mac_ctl.acc_en = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- position, integral, derivative ----------------
    logic                     w_sat_hi, w_sat_lo;
    logic signed [POS_W-1:0]  w_pos;
    logic signed [DIFF_W-1:0] w_sum, w_lim, w_diff;
    logic signed [ISUM_W-1:0] w_integ;

    always_comb begin
        // saturate the scaled offset to 24 bits
        w_sat_hi = !w_prod[PROD_W-1] && (|w_prod[PROD_W-2:POS_W-1]);
        w_sat_lo =  w_prod[PROD_W-1] && !(&w_prod[PROD_W-2:POS_W-1]);
        if (w_sat_hi) begin
            w_pos = {1'b0, {(POS_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            w_pos = w_prod[POS_W-1:0];
        end

        // integral with symmetric clamp
        w_sum = DIFF_W'(r_isum) + DIFF_W'(w_pos);
        w_lim = $signed(DIFF_W'(w_cfg.integral_limit));
        if (w_sum > w_lim) begin
            w_integ = w_lim[ISUM_W-1:0];
        end else if (w_sum < -w_lim) begin
            w_integ = ISUM_W'(-w_lim);
        end else begin
            w_integ = w_sum[ISUM_W-1:0];
        end

        w_diff = DIFF_W'(w_pos) - DIFF_W'(r_prev_pos);
    end

    // ---------------- rounding: |acc| + half, drop fraction ----------------
    logic [ACC_W-1:0] w_abs, w_rnd;

    always_comb begin
        w_abs = w_acc[ACC_W-1] ? $unsigned(-w_acc) : $unsigned(w_acc);
        w_rnd = w_abs + ROUND_HALF;
    end

    // ---------------- final clamp and split ----------------
    logic [TURN_W-1:0]      w_speed;
    logic signed [TURN_W:0] w_turn;
    logic [1:0]             w_dir;

    always_comb begin
        w_speed = (r_mag > MAG_W'(w_cfg.turn_limit)) ? w_cfg.turn_limit : r_mag[TURN_W-1:0];
        // drive is the negated sum, so a positive sum steers left
        w_turn  = r_neg ? -$signed({1'b0, w_speed}) : $signed({1'b0, w_speed});
        if (w_speed == '0) begin
            w_dir = DIR_NONE;
        end else if (r_neg) begin
            w_dir = DIR_LEFT;
        end else begin
            w_dir = DIR_RIGHT;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_offset <= i_line.line_offset;
        end
        if (r_state == S_SAT) begin
            r_pos   <= w_pos;
            r_integ <= w_integ;
            r_deriv <= w_diff;
        end
        if (r_state == S_ABS) begin
            r_mag <= w_rnd[ACC_W-1:FRAC_W];
            r_neg <= !w_acc[ACC_W-1] && (w_acc != '0);
        end
        if (w_load_out) begin
            r_turn_signed <= w_turn;
            r_turn_dir    <= w_dir;
            r_turn_mag    <= w_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos  <= '0;
            r_isum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_SAT) begin
                r_prev_pos <= w_pos;
                r_isum     <= w_integ;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_steer.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_steer.valid       = r_out_valid;
    assign o_steer.turn_signed = r_turn_signed;
    assign o_steer.turn_dir    = r_turn_dir;
    assign o_steer.turn_mag    = r_turn_mag;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_POS))
        else $error("accepted request did not start the sequencer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_steer.ready) |=> (r_state == S_OUT))
        else $error("result overwrote a pending output");

    a_dir_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_turn_dir == DIR_NONE) == (r_turn_mag == '0)))
        else $error("direction and speed disagree");

    a_left_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_turn_dir == DIR_LEFT) |-> r_turn_signed[TURN_W])
        else $error("left turn with non-negative value");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result load did not return to idle");

endmodule
